FILE: hw/rtl/clipped_sprite_alpha_blit_core_macros.svh
// assertion macros for the clipped sprite alpha blit core
`ifndef CLIPPED_SPRITE_ALPHA_BLIT_CORE_MACROS_SVH
`define CLIPPED_SPRITE_ALPHA_BLIT_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSAB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CSAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/csab_pkg.sv
// shared types and constants for the clipped sprite alpha blit core
package csab_pkg;

    localparam int MAX_DIM = 1024;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = 11;
    localparam int ORG_W   = 12;
    localparam int CMP_W   = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
    localparam int POS_W   = ((CNT_W > ORG_W - 1) ? CNT_W : ORG_W - 1) + 2;
    localparam int ADDR_W  = 20;
    localparam int PROD_W  = POS_W - 1 + DIM_W;
    localparam int CH_W    = 8;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int IDX_W   = 3;

    localparam logic [CH_W-1:0] ALPHA_MAX  = 8'd255;
    localparam logic [CH_W-1:0] BLEND_BIAS = 8'd128;

    localparam logic [IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLEND_ENABLE  = 3'd6;

    typedef struct packed {
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
        logic [DIM_W-1:0]        sprite_width;
        logic [DIM_W-1:0]        sprite_height;
        logic [DIM_W-1:0]        frame_width;
        logic [DIM_W-1:0]        frame_height;
        logic                    blend_enable;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] src_c0;
        logic [CH_W-1:0] src_c1;
        logic [CH_W-1:0] src_c2;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] dst_c0;
        logic [CH_W-1:0] dst_c1;
        logic [CH_W-1:0] dst_c2;
    } pix_in_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [CH_W-1:0]   out_c0;
        logic [CH_W-1:0]   out_c1;
        logic [CH_W-1:0]   out_c2;
        logic [CH_W-1:0]   out_alpha;
    } pix_out_t;

endpackage

FILE: hw/rtl/clipped_sprite_alpha_blit_core.sv
// path: an accepted pixel is held in the input register, then in the result register,
// from which it transfers out
// throughput: one pixel per cycle; input register and result register each take
// a new pixel whenever the stage after them moves on
// reset: synchronous active-low aresetn clears the counters, both valid flags and
// restores the configuration registers to their defaults
// top level of the clipped sprite alpha blit core
module clipped_sprite_alpha_blit_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csab_pkg::APB_AW-1:0]   paddr,
    input  logic [csab_pkg::APB_DW-1:0]   pwdata,
    output logic [csab_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_src_c0,
    input  logic [7:0]                    s_src_c1,
    input  logic [7:0]                    s_src_c2,
    input  logic [7:0]                    s_src_alpha,
    input  logic [7:0]                    s_dst_c0,
    input  logic [7:0]                    s_dst_c1,
    input  logic [7:0]                    s_dst_c2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_enable,
    output logic [19:0]                   m_write_address,
    output logic [7:0]                    m_out_c0,
    output logic [7:0]                    m_out_c1,
    output logic [7:0]                    m_out_c2,
    output logic [7:0]                    m_out_alpha,
    output logic                          m_last_pixel
);
    import csab_pkg::*;
    `include "clipped_sprite_alpha_blit_core_macros.svh"

    cfg_t                    cfg;
    logic signed [POS_W-1:0] pos_x, pos_y;
    logic                    ctr_last;
    logic                    in_xfer;
    logic                    out_adv;

    logic                    in_valid_reg;
    pix_in_t                 in_pix_reg;
    logic signed [POS_W-1:0] in_x_reg, in_y_reg;
    logic                    in_last_reg;

    pix_out_t                res;
    logic                    out_valid_reg;
    pix_out_t                out_pix_reg;
    logic                    out_last_reg;

    csab_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csab_ctr u_ctr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_xfer),
        .cfg     (cfg),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .last    (ctr_last)
    );

    csab_pix u_pix (
        .cfg   (cfg),
        .pos_x (in_x_reg),
        .pos_y (in_y_reg),
        .pix   (in_pix_reg),
        .res   (res)
    );

    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;
    assign in_xfer = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_pix_reg.src_c0    <= s_src_c0;
            in_pix_reg.src_c1    <= s_src_c1;
            in_pix_reg.src_c2    <= s_src_c2;
            in_pix_reg.src_alpha <= s_src_alpha;
            in_pix_reg.dst_c0    <= s_dst_c0;
            in_pix_reg.dst_c1    <= s_dst_c1;
            in_pix_reg.dst_c2    <= s_dst_c2;
            in_x_reg             <= pos_x;
            in_y_reg             <= pos_y;
            in_last_reg          <= ctr_last;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            out_pix_reg  <= res;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_enable  = out_pix_reg.write_enable;
    assign m_write_address = out_pix_reg.write_address;
    assign m_out_c0        = out_pix_reg.out_c0;
    assign m_out_c1        = out_pix_reg.out_c1;
    assign m_out_c2        = out_pix_reg.out_c2;
    assign m_out_alpha     = out_pix_reg.out_alpha;
    assign m_last_pixel    = out_last_reg;

    `CSAB_ASSERT_NEXT(a_in_capture, aclk, aresetn, in_xfer, in_valid_reg, "input pixel lost")
    `CSAB_ASSERT_NEXT(a_out_capture, aclk, aresetn, in_valid_reg && out_adv, out_valid_reg, "pixel lost")
    `CSAB_ASSERT_SAME(a_clip_zero, aclk, aresetn, m_valid && !m_write_enable, m_write_address == '0 && m_out_alpha == '0 && m_out_c0 == '0, "clipped pixel carries data")

endmodule

FILE: hw/rtl/csab_cfg.sv
// apb configuration register file
module csab_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csab_pkg::APB_AW-1:0]   paddr,
    input  logic [csab_pkg::APB_DW-1:0]   pwdata,
    output logic [csab_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output csab_pkg::cfg_t                cfg
);
    import csab_pkg::*;

    cfg_t            cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.sprite_width  <= DIM_W'(1);
            cfg_reg.sprite_height <= DIM_W'(1);
            cfg_reg.frame_width   <= DIM_W'(1024);
            cfg_reg.frame_height  <= DIM_W'(1024);
            cfg_reg.blend_enable  <= 1'b1;
        end else if (wr_en) begin
            case (idx)
                REG_ORIGIN_X:      cfg_reg.origin_x      <= pwdata[ORG_W-1:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= pwdata[ORG_W-1:0];
                REG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= pwdata[DIM_W-1:0];
                REG_SPRITE_HEIGHT: cfg_reg.sprite_height <= pwdata[DIM_W-1:0];
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= pwdata[DIM_W-1:0];
                REG_BLEND_ENABLE:  cfg_reg.blend_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ORIGIN_X:      prdata = APB_DW'(unsigned'(cfg_reg.origin_x));
            REG_ORIGIN_Y:      prdata = APB_DW'(unsigned'(cfg_reg.origin_y));
            REG_SPRITE_WIDTH:  prdata = APB_DW'(cfg_reg.sprite_width);
            REG_SPRITE_HEIGHT: prdata = APB_DW'(cfg_reg.sprite_height);
            REG_FRAME_WIDTH:   prdata = APB_DW'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:  prdata = APB_DW'(cfg_reg.frame_height);
            REG_BLEND_ENABLE:  prdata = APB_DW'(cfg_reg.blend_enable);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/csab_ctr.sv
// raster column and row counters with frame position of the current pixel
module csab_ctr (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  csab_pkg::cfg_t                    cfg,
    output logic signed [csab_pkg::POS_W-1:0] pos_x,
    output logic signed [csab_pkg::POS_W-1:0] pos_y,
    output logic                              last
);
    import csab_pkg::*;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] w_eff, h_eff, col_p1, row_p1;
    logic             col_wrap, row_wrap;

    // zero acts as one, oversize saturates
    function automatic logic [CMP_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [CMP_W-1:0] dz;
        dz = CMP_W'(d);
        if (d == '0)
            return CMP_W'(1);
        else if (dz > CMP_W'(MAX_DIM))
            return CMP_W'(MAX_DIM);
        else
            return dz;
    endfunction

    always_comb begin
        w_eff    = eff_dim(cfg.sprite_width);
        h_eff    = eff_dim(cfg.sprite_height);
        col_p1   = CMP_W'(col_reg) + CMP_W'(1);
        row_p1   = CMP_W'(row_reg) + CMP_W'(1);
        col_wrap = col_p1 >= w_eff;
        row_wrap = row_p1 >= h_eff;
        last     = col_wrap && row_wrap;
        col_next = col_wrap ? '0 : col_p1[CNT_W-1:0];
        row_next = col_wrap ? (row_wrap ? '0 : row_p1[CNT_W-1:0]) : row_reg;
        pos_x    = POS_W'(cfg.origin_x) + POS_W'(col_reg);
        pos_y    = POS_W'(cfg.origin_y) + POS_W'(row_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hw/rtl/csab_pix.sv
// clipping, address and source-over blend (or plain copy when blending is off) for one pixel
module csab_pix (
    input  csab_pkg::cfg_t                    cfg,
    input  logic signed [csab_pkg::POS_W-1:0] pos_x,
    input  logic signed [csab_pkg::POS_W-1:0] pos_y,
    input  csab_pkg::pix_in_t                 pix,
    output csab_pkg::pix_out_t                res
);
    import csab_pkg::*;

    logic [POS_W-2:0]  xu, yu;
    logic              in_frame;
    logic [PROD_W-1:0] addr_full;

    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] s,
                                             input logic [CH_W-1:0] d,
                                             input logic [CH_W-1:0] a);
        logic [2*CH_W-1:0] acc;
        acc = {{CH_W{1'b0}}, s} * {{CH_W{1'b0}}, a}
            + {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, ALPHA_MAX - a}
            + (2*CH_W)'(BLEND_BIAS);
        return acc[2*CH_W-1:CH_W];
    endfunction

    always_comb begin
        xu        = pos_x[POS_W-2:0];
        yu        = pos_y[POS_W-2:0];
        in_frame  = !pos_x[POS_W-1] && !pos_y[POS_W-1]
                 && (xu < (POS_W-1)'(cfg.frame_width))
                 && (yu < (POS_W-1)'(cfg.frame_height));
        addr_full = PROD_W'(yu) * PROD_W'(cfg.frame_width) + PROD_W'(xu);
        res       = '0;
        if (in_frame) begin
            res.write_enable  = 1'b1;
            res.write_address = addr_full[ADDR_W-1:0];
            res.out_alpha     = pix.src_alpha;
            if (cfg.blend_enable) begin
                res.out_c0 = blend(pix.src_c0, pix.dst_c0, pix.src_alpha);
                res.out_c1 = blend(pix.src_c1, pix.dst_c1, pix.src_alpha);
                res.out_c2 = blend(pix.src_c2, pix.dst_c2, pix.src_alpha);
            end else begin
                res.out_c0 = pix.src_c0;
                res.out_c1 = pix.src_c1;
                res.out_c2 = pix.src_c2;
            end
        end
    end

endmodule
